// ===== hw/rtl/two_level_tag_cache_lookup_fill_unit_assert.svh =====
// Assertion macros for the two-level tag cache lookup and fill unit.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef TWO_LEVEL_TAG_CACHE_LOOKUP_FILL_UNIT_ASSERT_SVH
`define TWO_LEVEL_TAG_CACHE_LOOKUP_FILL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TLCACHE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TLCACHE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TLCACHE_ASSERT_SAME(label, ante, cons, msg)
`define TLCACHE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/tlcache_pkg.sv =====
// Shared constants, types and address decode for the tag cache unit.
// No dependencies; used by the request interface, the top level and the testbench.
`timescale 1ns / 1ps

package tlcache_pkg;

	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned YTAG_W      = 10;
	localparam int unsigned ROW_W       = 13;
	localparam int unsigned NUM_ROWS    = 1 << ROW_W;
	localparam int unsigned Y_DEPTH_DEF = 4;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_FILL   = 1'b1;

	typedef logic [YTAG_W-1:0] ytag_t;
	typedef logic [ROW_W-1:0]  row_idx_t;

	// Row = {x bank, y bank, x index, y index, x tag}.
	function automatic row_idx_t row_of(input logic [ADDR_W-1:0] a);
		return {a[9], a[11], a[16:13], a[20:17], a[30:28]};
	endfunction

	function automatic ytag_t ytag_of(input logic [ADDR_W-1:0] a);
		return {a[27:21], a[12:10]};
	endfunction

endpackage

// ===== hw/rtl/tlcache_req_if.sv =====
// Request channel of the tag cache unit: command and address.
// Depends on tlcache_pkg.
`timescale 1ns / 1ps

interface tlcache_req_if import tlcache_pkg::*;;
	logic              valid;
	logic              ready;
	logic              command;
	logic [ADDR_W-1:0] address;

	modport source (output valid, command, address, input ready);
	modport sink (input valid, command, address, output ready);
endinterface

// ===== hw/rtl/tlcache_rsp_if.sv =====
// Response channel of the tag cache unit: the hit flag.
// No dependencies.
`timescale 1ns / 1ps

interface tlcache_rsp_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

// ===== hw/rtl/two_level_tag_cache_lookup_fill_unit.sv =====
// Tag store of a two-level cache: per-row LRU lists of y tags in one memory.
// Depends on tlcache_pkg, tlcache_req_if, tlcache_rsp_if and the assert header.
`timescale 1ns / 1ps

// Channel  Modport  Payload
// req      sink     command, address
// rsp      source   hit
//
// One request per cycle is accepted unless clearing or stalled; each gives one response.
// The row memory has one read and one write port; a request that follows one
// to the same row takes the written row from a forwarding register.
// After reset a clearing pass writes all 8192 rows, one per cycle, before
// the first request is accepted. A stalled response holds the stage behind it.

`include "two_level_tag_cache_lookup_fill_unit_assert.svh"

module two_level_tag_cache_lookup_fill_unit import tlcache_pkg::*; #(
	parameter int unsigned Y_DEPTH = Y_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tlcache_req_if.sink   req,
	tlcache_rsp_if.source rsp
);

	localparam int unsigned CNT_W    = $clog2(Y_DEPTH + 1);
	localparam int unsigned POS_W    = (Y_DEPTH > 1) ? $clog2(Y_DEPTH) : 1;
	localparam int unsigned TAGS_W   = Y_DEPTH * YTAG_W;
	localparam int unsigned ROW_BITS = CNT_W + TAGS_W;

	typedef logic [Y_DEPTH-1:0][YTAG_W-1:0] tags_t;

	logic [ROW_BITS-1:0] tag_mem [NUM_ROWS];

	logic                clr_busy_q;
	row_idx_t            clr_addr_q;

	logic                valid_s1;
	logic                cmd_s1;
	row_idx_t            row_s1;
	ytag_t               ytag_s1;
	logic                fwd_s1;
	logic [ROW_BITS-1:0] fwd_data_s1;
	logic [ROW_BITS-1:0] row_rd_s1;

	logic                out_valid_q;
	logic                hit_q;

	logic                out_free;
	logic                s1_adv;
	logic                req_acc;
	row_idx_t            req_row;

	logic [ROW_BITS-1:0] cur_row;
	logic [CNT_W-1:0]    cur_cnt;
	tags_t               cur_tags;
	logic                found;
	logic [POS_W-1:0]    hit_pos;
	logic [CNT_W-1:0]    new_cnt;
	tags_t               new_tags;

	logic                wr_en;
	row_idx_t            wr_addr;
	logic [ROW_BITS-1:0] wr_data;

	assign out_free  = !out_valid_q || rsp.ready;
	assign s1_adv    = valid_s1 && out_free;
	assign req.ready = !clr_busy_q && (!valid_s1 || out_free);
	assign req_acc   = req.valid && req.ready;
	assign req_row   = row_of(req.address);

	// Row update: a hit moves the first match to the front, a fill pushes at the front.
	always_comb begin
		cur_row  = fwd_s1 ? fwd_data_s1 : row_rd_s1;
		cur_cnt  = cur_row[ROW_BITS-1 -: CNT_W];
		cur_tags = tags_t'(cur_row[TAGS_W-1:0]);
		found    = 1'b0;
		hit_pos  = '0;
		for (int i = 0; i < Y_DEPTH; i++) begin
			if (!found && (CNT_W'(i) < cur_cnt) && (cur_tags[i] == ytag_s1)) begin
				found   = 1'b1;
				hit_pos = POS_W'(i);
			end
		end
		new_tags = cur_tags;
		new_cnt  = cur_cnt;
		if (cmd_s1 == CMD_FILL) begin
			new_tags[0] = ytag_s1;
			for (int i = 1; i < Y_DEPTH; i++) begin
				new_tags[i] = cur_tags[i-1];
			end
			new_cnt = (cur_cnt < CNT_W'(Y_DEPTH)) ? cur_cnt + CNT_W'(1) : cur_cnt;
		end else if (found) begin
			new_tags[0] = cur_tags[hit_pos];
			for (int i = 1; i < Y_DEPTH; i++) begin
				if (POS_W'(i) <= hit_pos) begin
					new_tags[i] = cur_tags[i-1];
				end
			end
		end
	end

	assign wr_en   = clr_busy_q || s1_adv;
	assign wr_addr = clr_busy_q ? clr_addr_q : row_s1;
	assign wr_data = clr_busy_q ? '0 : {new_cnt, TAGS_W'(new_tags)};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			row_rd_s1 <= tag_mem[req_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + row_idx_t'(1);
			if (clr_addr_q == row_idx_t'(NUM_ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
			// The memory read misses a write in this same cycle to the same row.
			fwd_s1   <= s1_adv && (row_s1 == req_row);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_s1      <= req.command;
			row_s1      <= req_row;
			ytag_s1     <= ytag_of(req.address);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			hit_q <= (cmd_s1 == CMD_LOOKUP) && found;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hit   = hit_q;

	`TLCACHE_ASSERT_SAME(a_no_work_while_clearing, clr_busy_q, !valid_s1 && !req_acc,
		"request in flight during the clearing pass")
	`TLCACHE_ASSERT_SAME(a_count_in_range, s1_adv, new_cnt <= CNT_W'(Y_DEPTH),
		"row fill count written beyond the list depth")
	`TLCACHE_ASSERT_NEXT(a_fill_never_hits, s1_adv && (cmd_s1 == CMD_FILL), !rsp.hit,
		"fill produced a hit")
	`TLCACHE_ASSERT_NEXT(a_stall_holds_stage, valid_s1 && !out_free,
		valid_s1 && $stable(row_s1) && $stable(ytag_s1),
		"stalled stage changed its request")

endmodule

// ===== sim/two_level_tag_cache_lookup_fill_unit_test.sv =====
// Self-checking testbench for the two-level tag cache lookup and fill unit.
// Depends on tlcache_pkg, tlcache_req_if, tlcache_rsp_if and the unit itself.
`timescale 1ns / 1ps

module two_level_tag_cache_lookup_fill_unit_test import tlcache_pkg::*;;

	localparam int unsigned WAYS = 4;
	localparam int unsigned RANDOM_ITEMS = 1100;
	localparam int unsigned PHASE_A_END = 375;
	localparam int unsigned PHASE_B_END = 750;
	localparam int unsigned HOLD_AT_RESULT = 850;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct {
		logic              command;
		logic [ADDR_W-1:0] address;
		bit                drain_first;
	} access_t;

	logic clk = 1'b0;
	logic arst_n;

	tlcache_req_if req ();
	tlcache_rsp_if rsp ();

	two_level_tag_cache_lookup_fill_unit #(.Y_DEPTH(WAYS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Shadow copy of the tag store: per row, an LRU list with MRU at index 0.
	ytag_t       lru_tags [NUM_ROWS][WAYS];
	int unsigned lru_len [NUM_ROWS];

	access_t     access_q[$];
	logic        expected_hits[$];
	int unsigned items_accepted;
	int unsigned results_seen;
	int unsigned fault_count;
	int unsigned hold_left;
	bit          hold_done;

	always #4 clk = ~clk;

	function automatic logic tag_lru_access(input logic cmd, input logic [ADDR_W-1:0] a);
		row_idx_t    r;
		ytag_t       y;
		int unsigned n;
		logic        found;
		r = {a[9], a[11], a[16:13], a[20:17], a[30:28]};
		y = {a[27:21], a[12:10]};
		found = 1'b0;
		if (cmd == CMD_LOOKUP) begin
			for (int unsigned i = 0; i < lru_len[r]; i++) begin
				if (!found && lru_tags[r][i] == y) begin
					for (int unsigned j = i; j > 0; j--)
						lru_tags[r][j] = lru_tags[r][j-1];
					lru_tags[r][0] = y;
					found = 1'b1;
				end
			end
		end else begin
			n = (lru_len[r] < WAYS) ? lru_len[r] + 1 : WAYS;
			for (int unsigned j = n - 1; j > 0; j--)
				lru_tags[r][j] = lru_tags[r][j-1];
			lru_tags[r][0] = y;
			lru_len[r] = n;
		end
		return found;
	endfunction

	// Builds an address for a given row and y tag. Bit 11 is shared by the
	// set index and the y tag, so the row wins there.
	function automatic logic [ADDR_W-1:0] address_for(input row_idx_t r, input ytag_t y,
			input logic [9:0] junk);
		logic [ADDR_W-1:0] a;
		a = '0;
		a[31] = junk[9];
		a[8:0] = junk[8:0];
		a[30:28] = r[2:0];
		a[20:17] = r[6:3];
		a[16:13] = r[10:7];
		a[11] = r[11];
		a[9] = r[12];
		a[27:21] = y[9:3];
		a[12] = y[2];
		a[10] = y[0];
		return a;
	endfunction

	function automatic int unsigned send_idle_pct(input int unsigned done);
		if (done < PHASE_A_END)
			return 23;
		if (done < PHASE_B_END)
			return 81;
		return 0;
	endfunction

	function automatic int unsigned recv_idle_pct(input int unsigned done);
		if (done < PHASE_A_END)
			return 81;
		if (done < PHASE_B_END)
			return 23;
		return 0;
	endfunction

	task automatic add_access(input logic cmd, input logic [ADDR_W-1:0] a, input bit drain);
		access_t item;
		item.command = cmd;
		item.address = a;
		item.drain_first = drain;
		access_q = {access_q, item};
	endtask

	// Request driver. A held transfer stays valid until accepted; a new one may
	// start only after the idle draw, and a marked one waits for a drained unit.
	always @(posedge clk or negedge arst_n) begin : request_driver
		logic offering;
		logic predicted;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.command <= CMD_LOOKUP;
			req.address <= '0;
		end else begin
			offering = req.valid;
			if (req.valid && req.ready) begin
				predicted = tag_lru_access(req.command, req.address);
				expected_hits = {expected_hits, predicted};
				items_accepted <= items_accepted + 1;
				offering = 1'b0;
			end
			if (!offering) begin
				if (access_q.size() != 0
						&& !(access_q[0].drain_first && expected_hits.size() != 0)
						&& $urandom_range(0, 99) >= send_idle_pct(items_accepted)) begin
					req.valid <= 1'b1;
					req.command <= access_q[0].command;
					req.address <= access_q[0].address;
					void'(access_q.pop_front());
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and checker.
	always @(posedge clk or negedge arst_n) begin : response_monitor
		logic want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen <= results_seen + 1;
				if (expected_hits.size() == 0) begin
					if (fault_count < MAX_REPORTS)
						$display("%0t: response hit=%b with no request outstanding",
							$realtime, rsp.hit);
					fault_count++;
				end else begin
					want = expected_hits.pop_front();
					if (rsp.hit !== want) begin
						if (fault_count < MAX_REPORTS)
							$display("%0t: hit mismatch, expected %b, got %b",
								$realtime, want, rsp.hit);
						fault_count++;
					end
				end
			end
			rsp.ready <= (hold_left == 0)
				&& ($urandom_range(0, 99) >= recv_idle_pct(items_accepted));
		end
	end

	// One long receiver hold-off while the sender keeps offering, so that the
	// unit backs up and drops its request ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin : stimulus
		row_idx_t    row_pool [16];
		ytag_t       tag_pool [8];
		row_idx_t    home;
		row_idx_t    r;
		logic [ADDR_W-1:0] a;
		int unsigned n;
		int unsigned choice;
		bit          drained;

		arst_n = 1'b0;

		// Address extremes, empty rows and ignored bits.
		add_access(CMD_LOOKUP, 32'h0000_0000, 1'b0);
		add_access(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0);
		add_access(CMD_FILL, 32'hFFFF_FFFF, 1'b0);
		add_access(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0);
		add_access(CMD_LOOKUP, 32'h7FFF_FE00, 1'b0);
		add_access(CMD_FILL, 32'h0000_0000, 1'b0);
		add_access(CMD_LOOKUP, 32'h8000_01FF, 1'b0);

		// Fill one row to capacity, promote its LRU entry, then overflow it.
		home = 13'h0A5C;
		add_access(CMD_FILL, address_for(home, 10'h010, 10'h155), 1'b0);
		add_access(CMD_FILL, address_for(home, 10'h020, 10'h2AA), 1'b0);
		add_access(CMD_FILL, address_for(home, 10'h040, 10'h000), 1'b0);
		add_access(CMD_FILL, address_for(home, 10'h080, 10'h3FF), 1'b0);
		add_access(CMD_LOOKUP, address_for(home, 10'h010, 10'h0F0), 1'b0);
		add_access(CMD_FILL, address_for(home, 10'h100, 10'h10F), 1'b0);
		add_access(CMD_LOOKUP, address_for(home, 10'h020, 10'h001), 1'b0);
		add_access(CMD_LOOKUP, address_for(home, 10'h010, 10'h200), 1'b0);
		// Duplicate fill; the lookup must match the copy nearest MRU.
		add_access(CMD_FILL, address_for(home, 10'h040, 10'h033), 1'b0);
		add_access(CMD_LOOKUP, address_for(home, 10'h040, 10'h0CC), 1'b0);
		add_access(CMD_LOOKUP, address_for(home, 10'h080, 10'h1C3), 1'b0);
		add_access(CMD_LOOKUP, address_for(home, 10'h100, 10'h3C0), 1'b0);
		// Same set and y tag under another x tag is a different row.
		add_access(CMD_LOOKUP, address_for(home ^ 13'h1, 10'h010, 10'h155), 1'b0);

		// Random part: a small working set of rows and tags so that hits,
		// promotions and evictions are common, plus fully random noise.
		foreach (row_pool[i])
			row_pool[i] = row_idx_t'($urandom);
		foreach (tag_pool[i])
			tag_pool[i] = ytag_t'($urandom);
		n = 0;
		drained = 1'b0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 49) == 0)
				row_pool[$urandom_range(0, 15)] = row_idx_t'($urandom);
			if ($urandom_range(0, 79) == 0)
				tag_pool[$urandom_range(0, 7)] = ytag_t'($urandom);
			r = row_pool[$urandom_range(0, 15)];
			a = address_for(r, tag_pool[$urandom_range(0, 7)], 10'($urandom));
			choice = $urandom_range(0, 99);
			if (choice < 55) begin
				// Lookup, then a fill of the same address, as after a miss.
				add_access(CMD_LOOKUP, a, !drained && n >= 500);
				add_access(CMD_FILL, a, 1'b0);
				if (n >= 500)
					drained = 1'b1;
				n += 2;
			end else if (choice < 80) begin
				add_access(CMD_LOOKUP, a, 1'b0);
				n++;
			end else begin
				add_access(logic'($urandom_range(0, 1)), $urandom, 1'b0);
				n++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (access_q.size() != 0 || req.valid)
			@(posedge clk);
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fault_count == 0 && expected_hits.size() == 0)
			$display("two_level_tag_cache_lookup_fill_unit_test: done, clean");
		else
			$display("two_level_tag_cache_lookup_fill_unit_test: done, errors");
		$finish;
	end

	// A run that has not finished by this time ends with the error report,
	// after the clearing pass and all the requests.
	initial begin
		#2_000_000;
		$display("two_level_tag_cache_lookup_fill_unit_test: done, errors");
		$finish;
	end

endmodule
